// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/ncdc_pkg.sv =====
// Types, constants and codes for the nearest center distance cost unit
`default_nettype none
package ncdc_pkg;
  localparam int MaxCenters = 16;
  localparam int MaxDim     = 64;
  localparam int CoordBits  = 16;
  localparam int CSlotW     = $clog2(MaxCenters);
  localparam int KSlotW     = $clog2(MaxDim);
  localparam int NcW        = 5;
  localparam int DimW       = 7;
  localparam int MemAw      = CSlotW + KSlotW;
  localparam int DiffW      = CoordBits + 1;
  localparam int SqW        = 2 * DiffW;
  localparam int SumW       = 39;
  localparam int RootW      = 20;
  localparam int DistW      = 19;
  localparam int TotalW     = 48;
  localparam int PaddrW     = 3;
  localparam int QDepth     = 4;
  localparam int QPtrW      = $clog2(QDepth);

  localparam logic [PaddrW-1:0] RegNumCenters = 3'd0;
  localparam logic [PaddrW-1:0] RegDimension  = 3'd4;

  localparam logic [SumW-1:0]   SumMax   = {SumW{1'b1}};
  localparam logic [DistW-1:0]  DistMax  = {DistW{1'b1}};
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_POINT = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RUN,
    B_DRAIN,
    B_SQRT,
    B_OUT
  } back_state_e;

  typedef struct packed {
    cmd_e                        kind;
    logic [CSlotW-1:0]           cslot;
    logic [KSlotW-1:0]           kslot;
    logic signed [CoordBits-1:0] value;
    logic                        last;
  } item_t;

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] operand;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } sqrt_rsp_t;
endpackage
`default_nettype wire

// ===== src/ncdc_if.sv =====
// Input and result channel interfaces
`default_nettype none
interface ncdc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [3:0]        center_slot;
  logic [5:0]        coord_slot;
  logic signed [15:0] coord_value;
  modport source (output valid, command, center_slot, coord_slot, coord_value, input ready);
  modport sink (input valid, command, center_slot, coord_slot, coord_value, output ready);
endinterface

interface ncdc_out_if;
  logic        valid;
  logic        ready;
  logic [18:0] min_distance;
  logic [47:0] total_cost;
  modport source (output valid, min_distance, total_cost, input ready);
  modport sink (input valid, min_distance, total_cost, output ready);
endinterface
`default_nettype wire

// ===== src/ncdc_front.sv =====
// Front end: register port, word intake, classification and point coordinate count
`default_nettype none
module ncdc_front (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  ncdc_in_if.sink                         req_i,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [ncdc_pkg::PaddrW-1:0]     paddr,
  input  wire  [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  wire                             q_full_i,
  output logic                            push_o,
  output ncdc_pkg::item_t                 item_o,
  output logic [ncdc_pkg::NcW-1:0]        num_centers_o
);
  import ncdc_pkg::*;

  logic [NcW-1:0]  nc_q;
  logic [DimW-1:0] dim_q;
  logic [DimW-1:0] count_q, count_d;
  logic [DimW-1:0] nd_eff;
  logic [DimW-1:0] count_inc;
  logic            accept;
  logic            is_last;
  cmd_e            kind;

  assign pready        = 1'b1;
  assign num_centers_o = nc_q;
  assign req_i.ready   = !q_full_i;
  assign accept        = req_i.valid && !q_full_i;
  assign kind          = cmd_e'(req_i.command);

  always_comb begin
    case (paddr)
      RegNumCenters: prdata = {{(32-NcW){1'b0}}, nc_q};
      RegDimension:  prdata = {{(32-DimW){1'b0}}, dim_q};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    if (dim_q == '0) begin
      nd_eff = DimW'(1);
    end else if (dim_q > DimW'(MaxDim)) begin
      nd_eff = DimW'(MaxDim);
    end else begin
      nd_eff = dim_q;
    end
  end

  assign count_inc = count_q + DimW'(1);
  assign is_last   = (count_inc >= nd_eff);

  always_comb begin
    count_d = count_q;
    if (accept && kind == CMD_POINT) begin
      count_d = is_last ? '0 : count_inc;
    end
  end

  // drop the unused command here so the back end never sees it
  assign push_o = accept && (kind != CMD_NOP);

  always_comb begin
    item_o       = '0;
    item_o.kind  = kind;
    item_o.cslot = req_i.center_slot;
    item_o.value = req_i.coord_value;
    item_o.last  = is_last;
    if (kind == CMD_POINT) begin
      item_o.kslot = count_q[DimW-1] ? {KSlotW{1'b1}} : count_q[KSlotW-1:0];
    end else begin
      item_o.kslot = req_i.coord_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q    <= NcW'(1);
      dim_q   <= DimW'(2);
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (psel && penable && pwrite) begin
        case (paddr)
          RegNumCenters: nc_q  <= pwdata[NcW-1:0];
          RegDimension:  dim_q <= pwdata[DimW-1:0];
          default:       ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/ncdc_queue.sv =====
// Short queue of classified words between front and back
`default_nettype none
module ncdc_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  ncdc_pkg::item_t item_i,
  output logic            full_o,
  input  wire             pop_i,
  output logic            valid_o,
  output ncdc_pkg::item_t item_o
);
  import ncdc_pkg::*;

  item_t            mem_q [QDepth];
  logic [QPtrW:0]   wr_q, rd_q;

  assign full_o  = (wr_q[QPtrW] != rd_q[QPtrW]) && (wr_q[QPtrW-1:0] == rd_q[QPtrW-1:0]);
  assign valid_o = (wr_q != rd_q);
  assign item_o  = mem_q[rd_q[QPtrW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[QPtrW-1:0]] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/ncdc_isqrt.sv =====
// Iterative floored square root, two radicand bits a cycle
`default_nettype none
module ncdc_isqrt (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ncdc_pkg::sqrt_req_t req_i,
  output ncdc_pkg::sqrt_rsp_t rsp_o
);
  import ncdc_pkg::*;

  logic [SumW-1:0] rem_q, res_q, bit_q;
  logic            done_q;
  logic [SumW:0]   trial;

  assign trial      = {1'b0, res_q} + {1'b0, bit_q};
  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q[RootW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.operand;
      res_q <= '0;
    end else if (bit_q != '0) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_q <= rem_q - trial[SumW-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        bit_q <= SumW'(1) << (SumW - 1);
      end else if (bit_q != '0) begin
        bit_q  <= bit_q >> 2;
        done_q <= (bit_q == SumW'(1));
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/ncdc_back.sv =====
// Back end: center store, per-center distance pipeline, minimum, cost and result register
`default_nettype none
module ncdc_back (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         q_valid_i,
  input  ncdc_pkg::item_t             item_i,
  output logic                        pop_o,
  input  wire  [ncdc_pkg::NcW-1:0]    num_centers_i,
  output ncdc_pkg::sqrt_req_t         sqrt_req_o,
  input  ncdc_pkg::sqrt_rsp_t         sqrt_rsp_i,
  ncdc_out_if.source                  rsp_o
);
  import ncdc_pkg::*;

  back_state_e state_q, state_d;

  logic [CoordBits-1:0]        mem [MaxCenters*MaxDim];
  logic [CoordBits-1:0]        rd_q;
  logic signed [CoordBits-1:0] x_q;
  logic [KSlotW-1:0]           k_q;
  logic                        last_q;
  logic [CSlotW-1:0]           c_q, c1_q, c2_q;
  logic                        v1_q, v2_q;
  logic [SqW-1:0]              sq_q;
  logic [SumW-1:0]             psum_q [MaxCenters];
  logic [SumW-1:0]             best_q;
  logic [TotalW-1:0]           total_q;
  logic                        out_valid_q;
  logic [DistW-1:0]            out_dist_q;
  logic [TotalW-1:0]           out_total_q;

  logic                        issue, out_load, sqrt_start;
  logic [NcW-1:0]              nc_eff;
  logic [CSlotW-1:0]           nc_last;
  logic signed [DiffW-1:0]     diff;
  logic signed [SqW-1:0]       prod;
  logic [SumW:0]               sum_raw;
  logic [SumW-1:0]             sum_sat;
  logic [DistW-1:0]            dist_sat;
  logic [TotalW:0]             tot_raw;
  logic [TotalW-1:0]           tot_sat;

  always_comb begin
    if (num_centers_i == '0) begin
      nc_eff = NcW'(1);
    end else if (num_centers_i > NcW'(MaxCenters)) begin
      nc_eff = NcW'(MaxCenters);
    end else begin
      nc_eff = num_centers_i;
    end
  end
  assign nc_last = CSlotW'(nc_eff - NcW'(1));

  assign diff    = DiffW'(x_q) - DiffW'($signed(rd_q));
  assign prod    = diff * diff;
  assign sum_raw = {1'b0, psum_q[c2_q]} + (SumW+1)'(sq_q);
  assign sum_sat = sum_raw[SumW] ? SumMax : sum_raw[SumW-1:0];

  assign dist_sat = (sqrt_rsp_i.root > RootW'(DistMax)) ? DistMax
                                                        : sqrt_rsp_i.root[DistW-1:0];
  assign tot_raw  = {1'b0, total_q} + (TotalW+1)'(dist_sat);
  assign tot_sat  = tot_raw[TotalW] ? TotalMax : tot_raw[TotalW-1:0];

  assign sqrt_req_o.start   = sqrt_start;
  assign sqrt_req_o.operand = best_q;

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.min_distance = out_dist_q;
  assign rsp_o.total_cost   = out_total_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i && item_i.kind == CMD_POINT) begin
          state_d = B_RUN;
        end
      end
      B_RUN: begin
        if (c_q == nc_last) begin
          state_d = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = last_q ? B_SQRT : B_IDLE;
        end
      end
      B_SQRT: begin
        if (sqrt_rsp_i.done) begin
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid_q || rsp_o.ready) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o      = 1'b0;
    issue      = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      B_IDLE:  pop_o      = q_valid_i;
      B_RUN:   issue      = 1'b1;
      B_DRAIN: sqrt_start = !v1_q && !v2_q && last_q;
      B_SQRT:  ;
      B_OUT:   out_load   = !out_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  // center store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.kind == CMD_LOAD) begin
      mem[{item_i.cslot, item_i.kslot}] <= item_i.value;
    end
    if (issue) begin
      rd_q <= mem[{c_q, k_q}];
    end
    if (pop_o) begin
      x_q    <= item_i.value;
      k_q    <= item_i.kslot;
      last_q <= item_i.last;
    end
    c1_q <= c_q;
    c2_q <= c1_q;
    sq_q <= $unsigned(prod);
    if (out_load) begin
      out_dist_q  <= dist_sat;
      out_total_q <= tot_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      c_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      best_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxCenters; i++) begin
        psum_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      if (pop_o) begin
        c_q <= '0;
      end else if (issue) begin
        c_q <= c_q + 1'b1;
      end
      if (pop_o && item_i.kind == CMD_CLEAR) begin
        total_q <= '0;
      end
      // accumulate one center per cycle; the lowest center wins a tie
      if (v2_q) begin
        psum_q[c2_q] <= sum_sat;
        if (c2_q == '0 || sum_sat < best_q) begin
          best_q <= sum_sat;
        end
      end
      if (sqrt_start) begin
        for (int i = 0; i < MaxCenters; i++) begin
          psum_q[i] <= '0;
        end
      end
      if (out_load) begin
        total_q     <= tot_sat;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/nearest_center_distance_cost_unit.sv =====
// Top level of the nearest center distance cost unit
//
//   channel   dir   handshake        payload
//   req_i     in    valid/ready      command, center_slot, coord_slot, coord_value
//   rsp_o     out   valid/ready      min_distance, total_cost
//   apb       in    psel/penable     num_centers @0x0, dimension @0x4
//
// A load or clear word is done as it leaves the queue; a point coordinate passes
// each center in turn through the single center-store read port and multiplier.
// The last coordinate of a point then runs the two-bit-a-cycle square root
// and loads the result register. Reset clears counters, sums and the total;
// the center store is not cleared. A four-word queue keeps intake going while the
// back end works or the result waits for rsp_o.ready.
`default_nettype none
module nearest_center_distance_cost_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  ncdc_in_if.sink    req_i,
  ncdc_out_if.source rsp_o,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire  [2:0] paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  import ncdc_pkg::*;

  logic           push, q_full, q_valid, pop;
  item_t          push_item, head_item;
  logic [NcW-1:0] num_centers;
  sqrt_req_t      sqrt_req;
  sqrt_rsp_t      sqrt_rsp;

  ncdc_front u_front (
    .clk_i, .rst_ni, .req_i,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .q_full_i(q_full), .push_o(push), .item_o(push_item),
    .num_centers_o(num_centers)
  );

  ncdc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .item_i(push_item), .full_o(q_full),
    .pop_i(pop), .valid_o(q_valid), .item_o(head_item)
  );

  ncdc_isqrt u_isqrt (
    .clk_i, .rst_ni, .req_i(sqrt_req), .rsp_o(sqrt_rsp)
  );

  ncdc_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .item_i(head_item), .pop_o(pop),
    .num_centers_i(num_centers),
    .sqrt_req_o(sqrt_req), .sqrt_rsp_i(sqrt_rsp),
    .rsp_o
  );
endmodule
`default_nettype wire

// ===== src/ncdc_checker.sv =====
// Port-level checker for the nearest center distance cost unit, with its bind
`default_nettype none
`include "assert_macros.svh"
module ncdc_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid,
  input wire        out_ready,
  input wire [18:0] min_distance,
  input wire [47:0] total_cost,
  input wire        pready
);
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(min_distance) && $stable(total_cost), "stalled word changed")
  `ASSERT_ALWAYS(a_pready, !rst_ni || pready, "pready dropped")
  `ASSERT_ALWAYS(a_rst_quiet, $past(!rst_ni) |-> !out_valid, "word shown right after reset")
endmodule

bind nearest_center_distance_cost_unit ncdc_checker u_ncdc_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid(rsp_o.valid),
  .out_ready(rsp_o.ready),
  .min_distance(rsp_o.min_distance),
  .total_cost(rsp_o.total_cost),
  .pready(pready)
);
`default_nettype wire
